// ===== design/psh_pkg.sv =====
package psh_pkg;

  // Permutation geometry; the algorithm fixes these.
  localparam int unsigned PERM_DEPTH = 256;
  localparam int unsigned PERM_W     = 8;
  localparam int unsigned PERM_AW    = $clog2(PERM_DEPTH);

  // Digest length register and its limits.
  localparam int unsigned LEN_W      = 7;
  localparam logic [LEN_W-1:0] LEN_RESET  = 7'd32;
  localparam logic [LEN_W-1:0] MAX_DIGEST = 7'd64;

  // Sponge constants.
  localparam logic [PERM_W-1:0] ABSORB_LIMIT = 8'd241;
  localparam logic [PERM_W-1:0] NIBBLE_BASE  = 8'd240;
  localparam logic [PERM_W-1:0] STRIDE_RESET = 8'd1;
  localparam logic [PERM_W-1:0] STRIDE_STEP  = 8'd2;
  localparam logic [PERM_AW-1:0] SHUFFLE_LAST = PERM_AW'(PERM_DEPTH - 1);

  // Default depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Input item kind codes as they arrive on the port.
  localparam logic [1:0] KIND_ABSORB  = 2'd0;
  localparam logic [1:0] KIND_SQUEEZE = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  typedef enum logic [1:0] {
    OP_ABSORB,
    OP_SQUEEZE,
    OP_RESTART
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [PERM_W-1:0] data;
  } cmd_t;

endpackage

// ===== design/psh_ram.sv =====
module psh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Read data holds its value while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/psh_front.sv =====
module psh_front #(
  parameter int unsigned QueueDepth = psh_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         data_byte_i,
  output logic               cmd_valid_o,
  output psh_pkg::cmd_t      cmd_o,
  input  logic               cmd_pop_i
);
  import psh_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  cmd_t            queue_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            accept;
  logic            push;
  logic            pop;
  cmd_t            new_cmd;
  logic            known_kind;

  assign in_stall_o  = (count_q == CntFull);
  assign accept      = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign pop         = cmd_pop_i && cmd_valid_o;

  // Classify the incoming kind; the unused code is taken and dropped.
  always_comb begin
    known_kind    = 1'b1;
    new_cmd.op    = OP_ABSORB;
    new_cmd.data  = data_byte_i;
    case (kind_i)
      KIND_ABSORB:  new_cmd.op = OP_ABSORB;
      KIND_SQUEEZE: new_cmd.op = OP_SQUEEZE;
      KIND_RESTART: new_cmd.op = OP_RESTART;
      default:      known_kind = 1'b0;
    endcase
  end

  assign push = accept && known_kind;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("command queue count exceeds its depth");

endmodule

// ===== design/psh_back.sv =====
module psh_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  psh_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  input  logic [psh_pkg::LEN_W-1:0]     output_length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [psh_pkg::PERM_W-1:0]    digest_byte_o,
  output logic                          last_o
);
  import psh_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS_CHK,
    ST_RD_I,
    ST_RD_J,
    ST_RD_Y,
    ST_WR_I,
    ST_WR_Y,
    ST_SQ_RD_OUT,
    ST_SQ_LOAD,
    ST_AB_RD_A,
    ST_AB_RD_N,
    ST_AB_WR_A,
    ST_AB_WR_N
  } state_e;

  state_e               state_q, state_d;
  logic [PERM_W-1:0]    i_q, i_d;
  logic [PERM_W-1:0]    j_q, j_d;
  logic [PERM_W-1:0]    a_q, a_d;
  logic [PERM_W-1:0]    w_q, w_d;
  logic [PERM_W-1:0]    x_q, x_d;
  logic [PERM_W-1:0]    byte_q, byte_d;
  logic                 nib_q, nib_d;
  logic                 shuf_q, shuf_d;
  op_e                  op_q, op_d;
  logic [PERM_AW-1:0]   rnd_q, rnd_d;
  logic [LEN_W-1:0]     remain_q, remain_d;
  logic [PERM_DEPTH-1:0] valid_q, valid_d;
  logic [PERM_AW-1:0]   raddr_q, raddr_d;
  logic                 out_valid_q, out_valid_d;
  logic [PERM_W-1:0]    digest_q, digest_d;
  logic                 last_q, last_d;

  logic                 ram_we;
  logic [PERM_AW-1:0]   ram_waddr;
  logic [PERM_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [PERM_AW-1:0]   ram_raddr;
  logic [PERM_W-1:0]    ram_rdata;
  logic [PERM_W-1:0]    rd_val;
  logic [PERM_AW-1:0]   nib_addr;
  logic [LEN_W-1:0]     clamp_len;

  psh_ram #(
    .Width (PERM_W),
    .Depth (PERM_DEPTH)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // An entry not written since restart still holds its identity value.
  assign rd_val    = valid_q[raddr_q] ? ram_rdata : raddr_q;
  assign nib_addr  = NIBBLE_BASE | {4'b0000, (nib_q ? byte_q[7:4] : byte_q[3:0])};
  assign clamp_len = (output_length_i > MAX_DIGEST) ? MAX_DIGEST : output_length_i;

  assign out_valid_o   = out_valid_q;
  assign digest_byte_o = digest_q;
  assign last_o        = last_q;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    w_d         = w_q;
    x_d         = x_q;
    byte_d      = byte_q;
    nib_d       = nib_q;
    shuf_d      = shuf_q;
    op_d        = op_q;
    rnd_d       = rnd_q;
    remain_d    = remain_q;
    valid_d     = valid_q;
    raddr_d     = raddr_q;
    out_valid_d = out_valid_q;
    digest_d    = digest_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    cmd_pop_o   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_i.op;
          case (cmd_i.op)
            OP_RESTART: begin
              valid_d = '0;
              i_d     = '0;
              j_d     = '0;
              a_d     = '0;
              w_d     = STRIDE_RESET;
            end
            OP_ABSORB: begin
              byte_d  = cmd_i.data;
              nib_d   = 1'b0;
              state_d = ST_ABS_CHK;
            end
            OP_SQUEEZE: begin
              remain_d = clamp_len;
              shuf_d   = 1'b1;
              rnd_d    = '0;
              state_d  = ST_RD_I;
            end
            default: ;
          endcase
        end
      end
      ST_ABS_CHK: begin
        if (a_q == ABSORB_LIMIT) begin
          shuf_d  = 1'b1;
          rnd_d   = '0;
          state_d = ST_RD_I;
        end else begin
          state_d = ST_AB_RD_A;
        end
      end
      ST_RD_I: begin
        i_d       = i_q + w_q;
        ram_re    = 1'b1;
        ram_raddr = i_q + w_q;
        state_d   = ST_RD_J;
      end
      ST_RD_J: begin
        x_d       = rd_val;
        ram_re    = 1'b1;
        ram_raddr = j_q + rd_val;
        state_d   = ST_RD_Y;
      end
      ST_RD_Y: begin
        j_d       = rd_val;
        ram_re    = 1'b1;
        ram_raddr = rd_val;
        state_d   = ST_WR_I;
      end
      ST_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = rd_val;
        state_d   = ST_WR_Y;
      end
      ST_WR_Y: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = x_q;
        if (shuf_q) begin
          rnd_d   = rnd_q + 1'b1;
          state_d = ST_RD_I;
          if (rnd_q == SHUFFLE_LAST) begin
            shuf_d = 1'b0;
            w_d    = w_q + STRIDE_STEP;
            a_d    = '0;
            if (op_q == OP_ABSORB) begin
              state_d = ST_AB_RD_A;
            end else if (remain_q == '0) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          state_d = ST_SQ_RD_OUT;
        end
      end
      ST_SQ_RD_OUT: begin
        ram_re    = 1'b1;
        ram_raddr = j_q;
        state_d   = ST_SQ_LOAD;
      end
      ST_SQ_LOAD: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          digest_d    = rd_val;
          last_d      = (remain_q == LEN_W'(1));
          remain_d    = remain_q - 1'b1;
          state_d     = (remain_q == LEN_W'(1)) ? ST_IDLE : ST_RD_I;
        end
      end
      ST_AB_RD_A: begin
        ram_re    = 1'b1;
        ram_raddr = a_q;
        state_d   = ST_AB_RD_N;
      end
      ST_AB_RD_N: begin
        x_d       = rd_val;
        ram_re    = 1'b1;
        ram_raddr = nib_addr;
        state_d   = ST_AB_WR_A;
      end
      ST_AB_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = a_q;
        ram_wdata = rd_val;
        state_d   = ST_AB_WR_N;
      end
      ST_AB_WR_N: begin
        ram_we    = 1'b1;
        ram_waddr = nib_addr;
        ram_wdata = x_q;
        a_d       = a_q + 1'b1;
        if (!nib_q) begin
          nib_d   = 1'b1;
          state_d = ST_ABS_CHK;
        end else begin
          j_d     = j_q + byte_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (ram_re) begin
      raddr_d = ram_raddr;
    end
    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      a_q         <= '0;
      w_q         <= STRIDE_RESET;
      x_q         <= '0;
      byte_q      <= '0;
      nib_q       <= 1'b0;
      shuf_q      <= 1'b0;
      op_q        <= OP_ABSORB;
      rnd_q       <= '0;
      remain_q    <= '0;
      valid_q     <= '0;
      raddr_q     <= '0;
      out_valid_q <= 1'b0;
      digest_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      a_q         <= a_d;
      w_q         <= w_d;
      x_q         <= x_d;
      byte_q      <= byte_d;
      nib_q       <= nib_d;
      shuf_q      <= shuf_d;
      op_q        <= op_d;
      rnd_q       <= rnd_d;
      remain_q    <= remain_d;
      valid_q     <= valid_d;
      raddr_q     <= raddr_d;
      out_valid_q <= out_valid_d;
      digest_q    <= digest_d;
      last_q      <= last_d;
    end
  end

  a_stride_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_q[0] == 1'b1)
    else $error("stride lost its odd value");

  a_absorb_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_q <= ABSORB_LIMIT)
    else $error("absorb position passed its limit");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("permutation read and write issued in one cycle");

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_SQ_LOAD))
    else $error("digest byte appeared outside the load step");

endmodule

// ===== design/permutation_sponge_hash_core.sv =====
// Spritz-style sponge hash over a 256-entry byte permutation held in a single
// RAM. Each input transfer carries a kind (0 absorb one message byte, 1 squeeze
// a digest, 2 restart to the identity permutation, 3 ignored) and a data byte.
// A squeeze returns output_length digest bytes (values above 64 count as 64,
// zero returns nothing) as output transfers, with last set on the final byte.
// The configuration channel writes output_length (reset 32) and must only be
// used while the core is idle. A small command queue decouples the input port
// from the execution engine, so up to QueueDepth commands are taken while the
// engine works. Every permutation update is a read-read-read-write-write
// sequence on the one RAM port pair. A full shuffle of 256 updates is
// inserted before the nibble that finds the absorb position at 241. A squeeze
// runs a full shuffle, then one update and an output read per digest byte,
// and waits while the output side stalls. Restart clears the per-entry valid
// flags at once, and a cleared entry reads back as its own index.
module permutation_sponge_hash_core #(
  parameter int unsigned QueueDepth = psh_pkg::QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input item channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [psh_pkg::PERM_W-1:0]    data_byte_i,
  // Digest byte channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [psh_pkg::PERM_W-1:0]    digest_byte_o,
  output logic                          last_o,
  // Configuration channel for output_length.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [psh_pkg::LEN_W-1:0]     cfg_data_i
);
  import psh_pkg::*;

  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  logic [LEN_W-1:0] output_length_q;

  // The length register is always ready for a transfer.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_length_q <= LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      output_length_q <= cfg_data_i;
    end
  end

  // The front end takes input transfers, decodes the kind and queues commands.
  psh_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // The back end owns the permutation and drives the digest output register.
  psh_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .output_length_i (output_length_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .digest_byte_o   (digest_byte_o),
    .last_o          (last_o)
  );

endmodule
